[hdl/deq_pkg.sv]
// Shared types and constants for the double-ended queue.
package deq_pkg;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_BAD_POS = 2'd3
  } stat_e;

endpackage

[hdl/deq_intf.sv]
// Request and response channel interfaces of the double-ended queue.
interface deq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [deq_pkg::CMD_W-1:0]     command;
  logic signed [deq_pkg::VALUE_W-1:0]   value;
  logic        [deq_pkg::POS_W-1:0]     position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

interface deq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic        [deq_pkg::STATUS_W-1:0]  status;
  logic signed [deq_pkg::VALUE_W-1:0]   front_value;
  logic signed [deq_pkg::VALUE_W-1:0]   back_value;
  logic        [deq_pkg::COUNT_W-1:0]   count;
  logic                                 is_empty;

  modport source (output valid, status, front_value, back_value, count, is_empty,
                  input ready);
  modport sink   (input valid, status, front_value, back_value, count, is_empty,
                  output ready);
endinterface

[hdl/deq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/double_ended_queue.sv]
// Double-ended queue held in a ring of CAPACITY RAM entries, addressed by a head pointer and
// an element count. Each request gives exactly one response with status, front, back, count
// and empty flag. Push and pop pass through accept, RAM read of front and back, and capture;
// insert and erase add one RAM read and one write back for every entry they move, plus one
// final step, since the ring has a single write port. A new request is taken as soon as the
// sequencer is idle, even while the previous response still waits in the output register.
// Two RAM copies share every write so that front and back can be read in the same cycle.
module double_ended_queue #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (DATA_WIDTH > deq_pkg::VALUE_W) ? DATA_WIDTH : deq_pkg::VALUE_W;
  localparam int PW = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_WR,
    S_ERS,
    S_ERS_WR,
    S_READ,
    S_CAP
  } state_e;

  state_e                         state_q, state_d;
  logic [AW-1:0]                  head_q, head_d;
  logic [CW-1:0]                  count_q, count_d;
  logic [CW-1:0]                  idx_q, idx_d;
  logic [CW-1:0]                  pos_q, pos_d;
  logic [DATA_WIDTH-1:0]          val_q, val_d;
  deq_pkg::stat_e                 stat_q, stat_d;

  logic                           out_valid_q, out_valid_d;
  logic [deq_pkg::STATUS_W-1:0]   out_status_q, out_status_d;
  logic [deq_pkg::VALUE_W-1:0]    out_front_q, out_front_d;
  logic [deq_pkg::VALUE_W-1:0]    out_back_q, out_back_d;
  logic [deq_pkg::COUNT_W-1:0]    out_count_q, out_count_d;
  logic                           out_empty_q, out_empty_d;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [DATA_WIDTH-1:0]          ram_wdata;
  logic [AW-1:0]                  raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0]          rdata_a, rdata_b;

  logic                           accept;
  logic                           is_full;
  logic                           is_empty;
  logic [PW-1:0]                  req_pos;
  logic [PW-1:0]                  cnt_ext;
  logic [CW-1:0]                  idx_inc;
  logic [CW-1:0]                  idx_dec;
  deq_pkg::cmd_e                  req_cmd;

  // Ring slot of the element at offset ofs from the front.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] ofs);
    logic [AW:0] sum;
    sum = {1'b0, h} + (AW+1)'(ofs);
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [DATA_WIDTH-1:0] to_store(
    input logic signed [deq_pkg::VALUE_W-1:0] v
  );
    logic signed [XW-1:0] x;
    x = XW'(v);
    return x[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [deq_pkg::VALUE_W-1:0] to_out(input logic [DATA_WIDTH-1:0] r);
    logic signed [XW-1:0] x;
    x = XW'($signed(r));
    return x[deq_pkg::VALUE_W-1:0];
  endfunction

  assign accept   = req_i.valid && req_i.ready;
  assign is_full  = (count_q == CW'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign req_pos  = PW'(req_i.position);
  assign cnt_ext  = PW'(count_q);
  assign idx_inc  = idx_q + CW'(1);
  assign idx_dec  = idx_q - CW'(1);
  assign req_cmd  = deq_pkg::cmd_e'(req_i.command);

  assign req_i.ready = (state_q == S_IDLE);

  // Port A serves shift reads and the front; port B the back.
  always_comb begin
    unique case (state_q)
      S_INS:   raddr_a = slot(head_q, idx_dec);
      S_ERS:   raddr_a = slot(head_q, idx_inc);
      default: raddr_a = head_q;
    endcase
    raddr_b = is_empty ? head_q : slot(head_q, count_q - CW'(1));
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    val_d        = val_q;
    stat_d       = stat_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_front_d  = out_front_q;
    out_back_d   = out_back_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    ram_we       = 1'b0;
    ram_waddr    = slot(head_q, count_q);
    ram_wdata    = to_store(req_i.value);

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          stat_d  = deq_pkg::STAT_OK;
          state_d = S_READ;
          unique case (req_cmd)
            deq_pkg::CMD_PUSH_BACK: begin
              if (is_full) begin
                stat_d = deq_pkg::STAT_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            deq_pkg::CMD_PUSH_FRONT: begin
              if (is_full) begin
                stat_d = deq_pkg::STAT_FULL;
              end else begin
                head_d    = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
                ram_we    = 1'b1;
                ram_waddr = head_d;
                count_d   = count_q + CW'(1);
              end
            end
            deq_pkg::CMD_POP_BACK: begin
              if (is_empty) begin
                stat_d = deq_pkg::STAT_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            deq_pkg::CMD_POP_FRONT: begin
              if (is_empty) begin
                stat_d = deq_pkg::STAT_EMPTY;
              end else begin
                head_d  = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
                count_d = count_q - CW'(1);
              end
            end
            deq_pkg::CMD_INSERT: begin
              if (is_full) begin
                stat_d = deq_pkg::STAT_FULL;
              end else if (req_pos > cnt_ext) begin
                stat_d = deq_pkg::STAT_BAD_POS;
              end else begin
                idx_d   = count_q;
                pos_d   = CW'(req_i.position);
                val_d   = to_store(req_i.value);
                state_d = S_INS;
              end
            end
            deq_pkg::CMD_ERASE: begin
              if (req_pos >= cnt_ext) begin
                stat_d = deq_pkg::STAT_BAD_POS;
              end else begin
                idx_d   = CW'(req_i.position);
                state_d = S_ERS;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        if (idx_q > pos_q) begin
          state_d = S_INS_WR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = slot(head_q, pos_q);
          ram_wdata = val_q;
          count_d   = count_q + CW'(1);
          state_d   = S_READ;
        end
      end
      S_INS_WR: begin
        // move entry idx-1 up into idx
        ram_we    = 1'b1;
        ram_waddr = slot(head_q, idx_q);
        ram_wdata = rdata_a;
        idx_d     = idx_dec;
        state_d   = S_INS;
      end
      S_ERS: begin
        if (idx_inc < count_q) begin
          state_d = S_ERS_WR;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_READ;
        end
      end
      S_ERS_WR: begin
        // move entry idx+1 down into idx
        ram_we    = 1'b1;
        ram_waddr = slot(head_q, idx_q);
        ram_wdata = rdata_a;
        idx_d     = idx_inc;
        state_d   = S_ERS;
      end
      S_READ: begin
        state_d = S_CAP;
      end
      S_CAP: begin
        // hold until the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = stat_q;
          out_front_d  = is_empty ? '1 : to_out(rdata_a);
          out_back_d   = is_empty ? '1 : to_out(rdata_b);
          out_count_d  = deq_pkg::COUNT_W'(count_q);
          out_empty_d  = is_empty;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      pos_q        <= '0;
      val_q        <= '0;
      stat_q       <= deq_pkg::STAT_OK;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_front_q  <= '0;
      out_back_q   <= '0;
      out_count_q  <= '0;
      out_empty_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      pos_q        <= pos_d;
      val_q        <= val_d;
      stat_q       <= stat_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_front_q  <= out_front_d;
      out_back_q   <= out_back_d;
      out_count_q  <= out_count_d;
      out_empty_q  <= out_empty_d;
    end
  end

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.front_value = out_front_q;
  assign rsp_o.back_value  = out_back_q;
  assign rsp_o.count       = out_count_q;
  assign rsp_o.is_empty    = out_empty_q;

endmodule
